@@ rtl/detection_confidence_table_assert.svh @@
// ----------------------------------------------------------------------------
// detection_confidence_table_assert.svh
// Assertion macros for the detection confidence table.
// ----------------------------------------------------------------------------
`ifndef DETECTION_CONFIDENCE_TABLE_ASSERT_SVH
`define DETECTION_CONFIDENCE_TABLE_ASSERT_SVH

`ifndef SYNTH

// property holds at every clock edge outside reset
`define DCT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dct assertion failed");

// antecedent implies consequent on the next edge
`define DCT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dct next-cycle assertion failed");

`else

`define DCT_ASSERT(name, clk, rst, prop)
`define DCT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ rtl/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, codes and the confidence lookup for the detection
// confidence table.
// ----------------------------------------------------------------------------
package dct_pkg;

   // item modes
   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DETECTIONS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIVE_TIME      = 1'b1;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0]  MIN_DET_RESET   = 8'd15;
   localparam logic [15:0] LIVE_TIME_RESET = 16'd500;

   localparam logic [15:0] HITS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] label;
      logic [15:0] hits;
      logic [31:0] seen;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic start;     // latch the request beat, clear search flags
      logic scan_rd;   // read one entry at scan_addr
      logic update;    // write back the entry, build the result
      logic finish;    // load the output register
   } cmd_type;

   // logistic curve, round(65536 / (1 + e^-d)) capped at 65535, for d = -16 .. 16
   localparam int CONF_SPAN = 16;
   localparam logic [15:0] CONF_TABLE [0:2*CONF_SPAN] = '{
      16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd1,
      16'd3,     16'd8,     16'd22,    16'd60,    16'd162,   16'd439,
      16'd1179,  16'd3108,  16'd7812,  16'd17625, 16'd32768, 16'd47911,
      16'd57724, 16'd62428, 16'd64357, 16'd65097, 16'd65374, 16'd65476,
      16'd65514, 16'd65528, 16'd65533, 16'd65535, 16'd65535, 16'd65535,
      16'd65535, 16'd65535, 16'd65535
   };

   function automatic logic [15:0] conf_lookup(input logic [15:0] hits,
                                               input logic [7:0]  min_det);
      logic signed [16:0] diff;
      logic [5:0]         idx;
      diff = $signed({1'b0, hits}) - $signed({9'b0, min_det});
      if (diff < -17'sd16) begin
         idx = 6'd0;
      end else if (diff > 17'sd16) begin
         idx = 6'd32;
      end else begin
         idx = 6'(diff + 17'sd16);
      end
      return CONF_TABLE[idx];
   endfunction

endpackage

@@ rtl/dct_ram.sv @@
// ----------------------------------------------------------------------------
// dct_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module dct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dct_ctrl.sv @@
// ----------------------------------------------------------------------------
// dct_ctrl
// Sequencer: accepts a request beat, walks the entry RAM one address per
// cycle, then write-back and result load.
// ----------------------------------------------------------------------------
module dct_ctrl #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output dct_pkg::cmd_type               cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0] scan_addr
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] scan_addr_ff;
   logic              rsp_valid_ff;
   logic              out_free;
   logic              accept;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  scan_addr_ff <= '0;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_addr_ff == LAST_ADDR) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_addr_ff <= scan_addr_ff + ADDR_W'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // wait here only while the previous result is still unread
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd.start   = accept;
      cmd.scan_rd = (state_ff == ST_SCAN);
      cmd.update  = (state_ff == ST_UPDATE);
      cmd.finish  = (state_ff == ST_FINISH) && out_free;
   end

   assign scan_addr = scan_addr_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/dct_datapath.sv @@
// ----------------------------------------------------------------------------
// dct_datapath
// Entry RAM, valid bits, search and expiry logic, config registers and the
// result register.
// ----------------------------------------------------------------------------
module dct_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dct_pkg::cmd_type                  cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    scan_addr,
   input  logic                              req_mode,
   input  logic [15:0]                       req_label,
   input  logic [31:0]                       req_now_ms,
   input  logic                              csr_write_en,
   input  logic [dct_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dct_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_found,
   output logic [15:0]                       rsp_hit_count,
   output logic [15:0]                       rsp_confidence,
   output logic                              rsp_dropped
);

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W = $bits(dct_pkg::entry_type);

   // config
   logic [7:0]  min_det_ff;
   logic [15:0] live_time_ff;

   // latched request
   logic        mode_ff;
   logic [15:0] label_ff;
   logic [31:0] now_ff;

   // search state
   logic                   chk_valid_ff;
   logic [ADDR_W-1:0]      chk_idx_ff;
   logic                   match_ff;
   logic [ADDR_W-1:0]      match_idx_ff;
   logic [15:0]            match_hits_ff;
   logic                   free_ff;
   logic [ADDR_W-1:0]      free_idx_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;

   // result before the confidence lookup
   logic        res_found_ff;
   logic [15:0] res_hits_ff;
   logic        res_dropped_ff;

   // output register
   logic        out_found_ff;
   logic [15:0] out_hits_ff;
   logic [15:0] out_conf_ff;
   logic        out_dropped_ff;

   logic [ENTRY_W-1:0] rd_raw;
   dct_pkg::entry_type rd_entry;
   dct_pkg::entry_type wr_entry;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               is_add;
   logic               entry_live;
   logic               entry_hit;
   logic               first_hit;
   logic [31:0]        age;
   logic               expired;
   logic [15:0]        hits_inc;

   dct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry   = dct_pkg::entry_type'(rd_raw);
   assign is_add     = (mode_ff == dct_pkg::MODE_ADD);
   assign entry_live = valid_ff[chk_idx_ff];
   assign entry_hit  = entry_live && (rd_entry.label == label_ff);
   assign first_hit  = entry_hit && !match_ff;
   assign age        = now_ff - rd_entry.seen;
   assign expired    = age > {16'b0, live_time_ff};
   assign hits_inc   = (match_hits_ff == dct_pkg::HITS_MAX) ?
                       match_hits_ff : match_hits_ff + 16'd1;

   // write-back in add mode: refresh the matched entry, or claim the first free one
   always_comb begin
      wr_en         = cmd.update && is_add && (match_ff || free_ff);
      wr_addr       = match_ff ? match_idx_ff : free_idx_ff;
      wr_entry.label = label_ff;
      wr_entry.hits  = match_ff ? hits_inc : 16'd0;
      wr_entry.seen  = now_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_det_ff   <= dct_pkg::MIN_DET_RESET;
         live_time_ff <= dct_pkg::LIVE_TIME_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            dct_pkg::CSR_MIN_DETECTIONS: min_det_ff   <= csr_wdata[7:0];
            dct_pkg::CSR_LIVE_TIME:      live_time_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         valid_ff     <= '0;
      end else begin
         chk_valid_ff <= cmd.scan_rd;
         if (cmd.start) begin
            match_ff <= 1'b0;
            free_ff  <= 1'b0;
         end
         if (chk_valid_ff) begin
            if (first_hit) begin
               match_ff <= 1'b1;
            end
            // free slot is taken from the valid bits before cleanup
            if (!entry_live && !free_ff) begin
               free_ff <= 1'b1;
            end
            // the matched entry gets a fresh timestamp, so this add never ages it out
            if (is_add && entry_live && !first_hit && expired) begin
               valid_ff[chk_idx_ff] <= 1'b0;
            end
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff  <= req_mode;
         label_ff <= req_label;
         now_ff   <= req_now_ms;
      end
      chk_idx_ff <= scan_addr;
      if (chk_valid_ff && first_hit) begin
         match_idx_ff  <= chk_idx_ff;
         match_hits_ff <= rd_entry.hits;
      end
      if (chk_valid_ff && !entry_live && !free_ff) begin
         free_idx_ff <= chk_idx_ff;
      end
      if (cmd.update) begin
         if (is_add) begin
            res_found_ff   <= match_ff || free_ff;
            res_hits_ff    <= match_ff ? hits_inc : 16'd0;
            res_dropped_ff <= !match_ff && !free_ff;
         end else begin
            res_found_ff   <= match_ff;
            res_hits_ff    <= match_ff ? match_hits_ff : 16'd0;
            res_dropped_ff <= 1'b0;
         end
      end
      if (cmd.finish) begin
         out_found_ff   <= res_found_ff;
         out_hits_ff    <= res_hits_ff;
         out_conf_ff    <= res_found_ff ?
                           dct_pkg::conf_lookup(res_hits_ff, min_det_ff) : 16'd0;
         out_dropped_ff <= res_dropped_ff;
      end
   end

   assign rsp_found      = out_found_ff;
   assign rsp_hit_count  = out_hits_ff;
   assign rsp_confidence = out_conf_ff;
   assign rsp_dropped    = out_dropped_ff;

endmodule

@@ rtl/detection_confidence_table.sv @@
// ----------------------------------------------------------------------------
// detection_confidence_table
// Table of tracked labels with hit counts, last-seen times and a logistic
// confidence readout.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------------
//   req      | in  | req_valid/req_stall  | req_mode, req_label, req_now_ms
//   rsp      | out | rsp_valid/rsp_stall  | rsp_found, rsp_hit_count,
//            |     |                      | rsp_confidence, rsp_dropped
//   csr      | in  | csr_write_en         | csr_index, csr_wdata
//
// Each beat walks the entry RAM one address per cycle through its single read
// port. Reset clears the valid bits, the sequencer and the config registers
// at once; no clearing pass. A new request beat is taken while the previous
// result waits on rsp_stall; the block holds in its last step only if that
// result is still unread.
// ----------------------------------------------------------------------------
`include "detection_confidence_table_assert.svh"

module detection_confidence_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [15:0]                     req_label,
   input  logic [31:0]                     req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [15:0]                     rsp_hit_count,
   output logic [15:0]                     rsp_confidence,
   output logic                            rsp_dropped,
   input  logic                            csr_write_en,
   input  logic [dct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dct_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dct_pkg::cmd_type               cmd;
   logic [$clog2(TABLE_DEPTH)-1:0] scan_addr;

   dct_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .scan_addr (scan_addr)
   );

   dct_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .scan_addr      (scan_addr),
      .req_mode       (req_mode),
      .req_label      (req_label),
      .req_now_ms     (req_now_ms),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_found      (rsp_found),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_confidence (rsp_confidence),
      .rsp_dropped    (rsp_dropped)
   );

   `DCT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `DCT_ASSERT(a_cmd_exclusive, clock, reset, $onehot0(cmd))
   `DCT_ASSERT(a_no_overwrite, clock, reset, !cmd.finish || !rsp_valid || !rsp_stall)
   `DCT_ASSERT(a_absent_is_zero, clock, reset, !(rsp_valid && !rsp_found) || (rsp_hit_count == 16'd0 && rsp_confidence == 16'd0))
   `DCT_ASSERT(a_drop_not_found, clock, reset, !(rsp_valid && rsp_dropped) || !rsp_found)

endmodule

@@ tb/dct_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dct_checker
// Watches the request, result and register ports of the detection confidence
// table. It keeps its own copy of the label table and register settings,
// works out the result of every accepted request beat, and compares each
// accepted result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dct_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_mode,
   input  logic [15:0]                     req_label,
   input  logic [31:0]                     req_now_ms,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_found,
   input  logic [15:0]                     rsp_hit_count,
   input  logic [15:0]                     rsp_confidence,
   input  logic                            rsp_dropped,
   input  logic                            csr_write_en,
   input  logic [dct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dct_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              rsp_beats
);

   localparam int DEPTH      = 16;
   localparam int SPAN       = 16;
   localparam int PEND_DEPTH = 4;

   // logistic curve sampled at d = -16 .. 16
   localparam logic [15:0] LOGISTIC [0:2*SPAN] = '{
      16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd1,
      16'd3,     16'd8,     16'd22,    16'd60,    16'd162,   16'd439,
      16'd1179,  16'd3108,  16'd7812,  16'd17625, 16'd32768, 16'd47911,
      16'd57724, 16'd62428, 16'd64357, 16'd65097, 16'd65374, 16'd65476,
      16'd65514, 16'd65528, 16'd65533, 16'd65535, 16'd65535, 16'd65535,
      16'd65535, 16'd65535, 16'd65535
   };

   typedef struct packed {
      logic        found;
      logic [15:0] hits;
      logic [15:0] conf;
      logic        dropped;
   } track_result_type;

   logic [7:0]  min_det;
   logic [15:0] live_ms;
   logic        slot_used  [DEPTH];
   logic [15:0] slot_label [DEPTH];
   logic [15:0] slot_hits  [DEPTH];
   logic [31:0] slot_seen  [DEPTH];

   // outstanding predictions, oldest at pend_head
   track_result_type pending [PEND_DEPTH];
   int pend_head  = 0;
   int pend_tail  = 0;
   int pend_count = 0;
   int mismatches = 0;

   assign fail_count = mismatches;

   function automatic int find_slot(input logic [15:0] label);
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_used[i] && slot_label[i] == label) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic logic [15:0] confidence_for(input logic [15:0] hits);
      int d;
      d = int'(hits) - int'(min_det);
      if (d < -SPAN) begin
         d = -SPAN;
      end else if (d > SPAN) begin
         d = SPAN;
      end
      return LOGISTIC[d + SPAN];
   endfunction

   // updates the table copy for an add beat and returns the result of the beat
   function automatic track_result_type track_detection(input logic mode,
                                                        input logic [15:0] label,
                                                        input logic [31:0] now);
      track_result_type r;
      int               hit;
      int               free_slot;
      logic [31:0]      age;
      r = '0;
      if (mode == dct_pkg::MODE_ADD) begin
         hit = find_slot(label);
         if (hit >= 0) begin
            if (slot_hits[hit] != dct_pkg::HITS_MAX) begin
               slot_hits[hit] = slot_hits[hit] + 16'd1;
            end
            slot_seen[hit] = now;
         end else begin
            free_slot = -1;
            for (int i = DEPTH - 1; i >= 0; i--) begin
               if (!slot_used[i]) begin
                  free_slot = i;
               end
            end
            if (free_slot >= 0) begin
               slot_used[free_slot]  = 1'b1;
               slot_label[free_slot] = label;
               slot_hits[free_slot]  = 16'd0;
               slot_seen[free_slot]  = now;
            end else begin
               r.dropped = 1'b1;
            end
         end
         // expiry runs even when the add was dropped; age wraps mod 2^32
         for (int i = 0; i < DEPTH; i++) begin
            age = now - slot_seen[i];
            if (slot_used[i] && age > {16'd0, live_ms}) begin
               slot_used[i] = 1'b0;
            end
         end
      end
      hit = find_slot(label);
      if (hit >= 0) begin
         r.found = 1'b1;
         r.hits  = slot_hits[hit];
         r.conf  = confidence_for(slot_hits[hit]);
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      track_result_type want;
      track_result_type got;
      if (reset) begin
         min_det = dct_pkg::MIN_DET_RESET;
         live_ms = dct_pkg::LIVE_TIME_RESET;
         for (int i = 0; i < DEPTH; i++) begin
            slot_used[i] = 1'b0;
         end
         pend_head  = 0;
         pend_tail  = 0;
         pend_count = 0;
         rsp_beats <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               dct_pkg::CSR_MIN_DETECTIONS: begin
                  min_det = csr_wdata[7:0];
               end
               dct_pkg::CSR_LIVE_TIME: begin
                  live_ms = csr_wdata[15:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            want = track_detection(req_mode, req_label, req_now_ms);
            if (pend_count == PEND_DEPTH) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: too many request beats outstanding", $realtime);
               end
            end else begin
               pending[pend_tail] = want;
               pend_tail  = (pend_tail + 1) % PEND_DEPTH;
               pend_count = pend_count + 1;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_beats <= rsp_beats + 1;
            got = {rsp_found, rsp_hit_count, rsp_confidence, rsp_dropped};
            if (pend_count == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result beat with nothing outstanding:", $realtime);
                  $display("   found=%0d hits=%0d conf=%0d dropped=%0d",
                           got.found, got.hits, got.conf, got.dropped);
               end
            end else begin
               want       = pending[pend_head];
               pend_head  = (pend_head + 1) % PEND_DEPTH;
               pend_count = pend_count - 1;
               if (got.found !== want.found || got.hits !== want.hits ||
                   got.conf !== want.conf || got.dropped !== want.dropped) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected found=%0d hits=%0d conf=%0d dropped=%0d",
                              want.found, want.hits, want.conf, want.dropped);
                     $display("   actual   found=%0d hits=%0d conf=%0d dropped=%0d",
                              got.found, got.hits, got.conf, got.dropped);
                  end
               end
            end
         end
      end
   end

endmodule

@@ tb/tb_detection_confidence_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_detection_confidence_table
// Drives the detection confidence table with a directed sequence (empty and
// full table, drops, expiry at the live-time boundary, time wrap) and then
// random add/query traffic over several register settings, with random
// idling on both channels in all but the last setting, one long result
// hold-off. A final phase walks one label across the whole confidence
// curve. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_detection_confidence_table;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int CURVE_ADDS    = 40;
   localparam int POOL_MAX      = 24;

   logic                            clock        = 1'b0;
   logic                            reset        = 1'b1;
   logic                            req_valid    = 1'b0;
   logic                            req_stall;
   logic                            req_mode     = dct_pkg::MODE_ADD;
   logic [15:0]                     req_label    = '0;
   logic [31:0]                     req_now_ms   = '0;
   logic                            rsp_valid;
   logic                            rsp_stall    = 1'b0;
   logic                            rsp_found;
   logic [15:0]                     rsp_hit_count;
   logic [15:0]                     rsp_confidence;
   logic                            rsp_dropped;
   logic                            csr_write_en = 1'b0;
   logic [dct_pkg::CSR_INDEX_W-1:0] csr_index    = dct_pkg::CSR_MIN_DETECTIONS;
   logic [dct_pkg::CSR_DATA_W-1:0]  csr_wdata    = '0;

   int          fail_count;
   int          rsp_beats;
   int          beats_sent  = 0;
   bit          send_gaps   = 1'b0;
   bit          stall_gaps  = 1'b0;
   bit          want_hold   = 1'b0;
   bit          hold_done   = 1'b0;
   int          stall_left  = 0;
   int unsigned cycle_count = 0;
   logic [31:0] now_ms      = '0;
   logic [15:0] label_pool [POOL_MAX];

   detection_confidence_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_label      (req_label),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_confidence (rsp_confidence),
      .rsp_dropped    (rsp_dropped),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   dct_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_label      (req_label),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_confidence (rsp_confidence),
      .rsp_dropped    (rsp_dropped),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .rsp_beats      (rsp_beats)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("detection_confidence_table regression: fail");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (want_hold && !hold_done) begin
         hold_done  <= 1'b1;
         rsp_stall  <= 1'b1;
         stall_left <= HOLD_CYCLES;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_gaps && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 7);
      end
   end

   // call only right after posedge clock with the block idle
   task automatic write_regs(input logic [7:0] min_det, input logic [15:0] live_ms);
      csr_write_en <= 1'b1;
      csr_index    <= dct_pkg::CSR_MIN_DETECTIONS;
      csr_wdata    <= {8'($urandom), min_det};
      @(posedge clock);
      csr_index    <= dct_pkg::CSR_LIVE_TIME;
      csr_wdata    <= live_ms;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_beat(input logic mode, input logic [15:0] label,
                            input logic [31:0] now);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_label  <= label;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rsp_beats != beats_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly small time steps over a small label pool, so labels get re-hit,
   // the table fills and entries age out; some jumps and stray labels
   task automatic run_traffic(input int count, input int pool_n, input int unsigned live_ms);
      int unsigned step_max;
      int          pick;
      logic        mode;
      logic [15:0] label;
      step_max = live_ms / 6 + 2;
      for (int i = 0; i < POOL_MAX; i++) begin
         label_pool[i] = 16'($urandom);
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            now_ms = $urandom;
         end else if (pick < 8) begin
            now_ms = now_ms + $urandom_range(0, 3 * live_ms + 10);
         end else begin
            now_ms = now_ms + $urandom_range(0, step_max);
         end
         if ($urandom_range(0, 19) == 0) begin
            label = 16'($urandom);
         end else begin
            label = label_pool[$urandom_range(0, pool_n - 1)];
         end
         mode = ($urandom_range(0, 9) < 3) ? dct_pkg::MODE_QUERY : dct_pkg::MODE_ADD;
         send_beat(mode, label, now_ms);
      end
   endtask

   initial begin
      logic [7:0]  min_det;
      logic [15:0] live_ms;

      repeat (3) @(posedge clock);
      reset      <= 1'b0;
      send_gaps  = 1'b1;
      stall_gaps = 1'b1;

      // directed, reset settings (min 15, live 500)
      send_beat(dct_pkg::MODE_QUERY, 16'h0000, 32'd0);
      send_beat(dct_pkg::MODE_ADD,   16'h0000, 32'd0);
      send_beat(dct_pkg::MODE_ADD,   16'h0000, 32'd1);
      send_beat(dct_pkg::MODE_ADD,   16'hFFFF, 32'd2);
      send_beat(dct_pkg::MODE_QUERY, 16'hFFFF, 32'd3);
      for (int i = 1; i <= 14; i++) begin
         send_beat(dct_pkg::MODE_ADD, 16'h1000 + 16'(i), 32'd4);
      end
      // table full: dropped, nothing old enough to expire
      send_beat(dct_pkg::MODE_ADD,   16'hAAAA, 32'd5);
      // query does no cleanup even at a far time
      send_beat(dct_pkg::MODE_QUERY, 16'h0000, 32'hFFFF_FFFF);
      // dropped add, then the cleanup empties the table
      send_beat(dct_pkg::MODE_ADD,   16'h5555, 32'd1000);
      // time wrap: the second add, at wrapped age 496, re-hits the entry
      send_beat(dct_pkg::MODE_ADD,   16'h5555, 32'hFFFF_FF00);
      send_beat(dct_pkg::MODE_ADD,   16'h5555, 32'h0000_00F0);
      // age equal to live time is kept, one more removes it
      send_beat(dct_pkg::MODE_ADD,   16'h1234, 32'h0000_02E4);
      send_beat(dct_pkg::MODE_ADD,   16'h1234, 32'h0000_02E5);
      send_beat(dct_pkg::MODE_QUERY, 16'h5555, 32'h0000_02E5);
      wait_idle();

      write_regs(8'd0, 16'd0);
      run_traffic(200, 6, 0);
      wait_idle();

      write_regs(8'd255, 16'hFFFF);
      want_hold <= 1'b1;
      run_traffic(200, POOL_MAX, 65535);
      wait_idle();

      min_det = 8'($urandom);
      live_ms = 16'($urandom_range(20, 3000));
      write_regs(min_det, live_ms);
      run_traffic(250, 10, live_ms);
      wait_idle();

      write_regs(8'd15, 16'd500);
      run_traffic(200, 4, 500);
      wait_idle();

      // no idling from here on
      send_gaps  = 1'b0;
      stall_gaps = 1'b0;
      min_det = 8'($urandom_range(0, 40));
      live_ms = 16'($urandom);
      write_regs(min_det, live_ms);
      run_traffic(250, 12, live_ms);
      wait_idle();

      // one label walked from d = -20 to d = 19, past both ends of the curve
      write_regs(8'd20, 16'hFFFF);
      for (int n = 0; n < CURVE_ADDS; n++) begin
         send_beat(dct_pkg::MODE_ADD, 16'h0F0F, 32'h8000_0000);
      end
      wait_idle();

      if (fail_count == 0) begin
         $display("detection_confidence_table regression: pass");
      end else begin
         $display("detection_confidence_table regression: fail");
      end
      $finish;
   end

endmodule
